// ===== rtl/core/scb_pkg.sv =====
// shared types and constants for the sprite collision bitmap block
// holds the request codes, the control struct between pipeline stages and store sizing helpers
// no dependencies
`default_nettype none

package scb_pkg;

    localparam int MAP_WIDTH_DEF   = 600;
    localparam int MAP_HEIGHT_DEF  = 240;
    localparam int NUM_BITMAPS_DEF = 3;

    // bitmap store word, one read-modify-write per transaction
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        REQ_TEST  = 2'd0,
        REQ_MARK  = 2'd1,
        REQ_SET   = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
        logic in_map;
        logic opaque;
        logic last;
    } pix_ctrl_t;

    // each map row starts on a fresh word
    function automatic int words_per_row(input int map_width);
        return (map_width + WORD_BITS - 1) / WORD_BITS;
    endfunction

    function automatic int store_depth(input int map_width, input int map_height,
                                       input int num_bitmaps);
        return num_bitmaps * map_height * words_per_row(map_width);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scb_locate.sv =====
// pixel locate stages: map position, clipping and store word address
// depends on scb_pkg
`default_nettype none

module scb_locate #(
    parameter int MAP_WIDTH   = scb_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT  = scb_pkg::MAP_HEIGHT_DEF,
    parameter int NUM_BITMAPS = scb_pkg::NUM_BITMAPS_DEF,
    localparam int ADDR_W = $clog2(scb_pkg::store_depth(MAP_WIDTH, MAP_HEIGHT, NUM_BITMAPS))
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     adv,
    input  wire logic                     in_take,
    input  wire logic [1:0]               req_type,
    input  wire logic [1:0]               bitmap_select,
    input  wire logic signed [10:0]       origin_x,
    input  wire logic signed [10:0]       origin_y,
    input  wire logic [7:0]               col,
    input  wire logic [7:0]               row,
    input  wire logic [15:0]              pixel,
    input  wire logic                     last,
    output scb_pkg::pix_ctrl_t            s2_ctrl,
    output logic [ADDR_W-1:0]             s2_addr,
    output logic [scb_pkg::BIT_W-1:0]     s2_bit
);
    import scb_pkg::*;

    localparam int WPR         = words_per_row(MAP_WIDTH);
    localparam logic [ADDR_W-1:0] WPR_A   = ADDR_W'(WPR);
    localparam logic [ADDR_W-1:0] PLANE_A = ADDR_W'(MAP_HEIGHT * WPR);

    logic        s1_valid_reg;
    req_t        s1_req_reg;
    logic [1:0]  s1_sel_reg;
    logic [11:0] s1_px_reg;
    logic [11:0] s1_py_reg;
    logic        s1_opaque_reg;
    logic        s1_last_reg;

    pix_ctrl_t           s2_ctrl_reg;
    logic [ADDR_W-1:0]   s2_addr_reg;
    logic [BIT_W-1:0]    s2_bit_reg;

    logic [11:0]         px_sum;
    logic [11:0]         py_sum;
    logic                sel_ok;
    logic                x_ok;
    logic                y_ok;
    logic [10:0]         word_col;
    logic [ADDR_W-1:0]   addr_calc;

    // two's complement sums, sign bit kept in bit 11
    assign px_sum = {origin_x[10], origin_x} + {4'b0000, col};
    assign py_sum = {origin_y[10], origin_y} + {4'b0000, row};

    assign sel_ok   = {1'b0, s1_sel_reg} < 3'(NUM_BITMAPS);
    assign x_ok     = !s1_px_reg[11] && (s1_px_reg < 12'(MAP_WIDTH));
    assign y_ok     = !s1_py_reg[11] && (s1_py_reg < 12'(MAP_HEIGHT));
    assign word_col = s1_px_reg[10:0] >> BIT_W;
    assign addr_calc = ADDR_W'(s1_sel_reg) * PLANE_A
                     + ADDR_W'(s1_py_reg[9:0]) * WPR_A
                     + ADDR_W'(word_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_ctrl_reg  <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg       <= in_take;
            s2_ctrl_reg.valid  <= s1_valid_reg;
            s2_ctrl_reg.req    <= s1_req_reg;
            s2_ctrl_reg.in_map <= sel_ok && x_ok && y_ok;
            s2_ctrl_reg.opaque <= s1_opaque_reg;
            s2_ctrl_reg.last   <= s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_req_reg    <= req_t'(req_type);
            s1_sel_reg    <= bitmap_select;
            s1_px_reg     <= px_sum;
            s1_py_reg     <= py_sum;
            s1_opaque_reg <= pixel != 16'd0;
            s1_last_reg   <= last;

            s2_addr_reg   <= addr_calc;
            s2_bit_reg    <= s1_px_reg[BIT_W-1:0];
        end
    end

    assign s2_ctrl = s2_ctrl_reg;
    assign s2_addr = s2_addr_reg;
    assign s2_bit  = s2_bit_reg;

endmodule

`default_nettype wire

// ===== rtl/core/scb_store.sv =====
// bitmap word store with clearing sweep after reset and write-to-read forwarding
// depends on scb_pkg
`default_nettype none

module scb_store #(
    parameter int MAP_WIDTH   = scb_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT  = scb_pkg::MAP_HEIGHT_DEF,
    parameter int NUM_BITMAPS = scb_pkg::NUM_BITMAPS_DEF,
    localparam int ADDR_W = $clog2(scb_pkg::store_depth(MAP_WIDTH, MAP_HEIGHT, NUM_BITMAPS))
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [ADDR_W-1:0]             rd_addr,
    output logic [scb_pkg::WORD_BITS-1:0]      rd_word,
    input  wire logic                          wr_en,
    input  wire logic [ADDR_W-1:0]             wr_addr,
    input  wire logic [scb_pkg::WORD_BITS-1:0] wr_data,
    output logic                               busy
);
    import scb_pkg::*;

    localparam int DEPTH = store_depth(MAP_WIDTH, MAP_HEIGHT, NUM_BITMAPS);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    rd_addr_reg;

    logic                 clr_busy_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;

    logic                 fwd_valid_reg;
    logic [ADDR_W-1:0]    fwd_addr_reg;
    logic [WORD_BITS-1:0] fwd_data_reg;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    assign mem_we    = clr_busy_reg || wr_en;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clr_busy_reg ? '0 : wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == LAST_A)
                    clr_busy_reg <= 1'b0;
                else
                    clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (wr_en && !clr_busy_reg)
                fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en && !clr_busy_reg)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // a write in the same cycle as the read is not yet in the read data
    assign rd_word = (fwd_valid_reg && fwd_addr_reg == rd_addr_reg) ? fwd_data_reg : rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sprite_collision_bitmap.sv =====
// top level of the sprite collision bitmap block
// instantiates scb_locate and scb_store, uses scb_pkg
//
// usage
//   input channel: one sprite pixel per transaction (in_valid / in_stall), carrying the
//   request type, bitmap select, sprite origin, column and row offset, raw pixel and the
//   last-of-run mark
//   output channel: one transaction (out_valid / out_stall) with collided for each input
//   pixel marked last; pixels without last give nothing on the output
// throughput: one pixel per cycle unless held; each pixel is one read-modify-write of a
//   64-bit store word; a word written by the previous pixel is forwarded to the next read
// result path: a last pixel passes two locate stages, one memory read stage, then the
//   output register, which shows its result
// reset: all bitmaps are cleared by a sweep of one store word per cycle over all
//   NUM_BITMAPS * MAP_HEIGHT * ceil(MAP_WIDTH / 64) store words (7200 at the default size);
//   in_stall stays high for the whole sweep
// stall: while a result waits in the output register and out_stall is high the whole
//   pipeline holds and in_stall is raised; otherwise pixels keep flowing
`default_nettype none

module sprite_collision_bitmap #(
    parameter int MAP_WIDTH   = scb_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT  = scb_pkg::MAP_HEIGHT_DEF,
    parameter int NUM_BITMAPS = scb_pkg::NUM_BITMAPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic [1:0]         bitmap_select,
    input  wire logic signed [10:0] origin_x,
    input  wire logic signed [10:0] origin_y,
    input  wire logic [7:0]         col,
    input  wire logic [7:0]         row,
    input  wire logic [15:0]        pixel,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    collided
);
    import scb_pkg::*;

    localparam int ADDR_W = $clog2(store_depth(MAP_WIDTH, MAP_HEIGHT, NUM_BITMAPS));

    // pipeline moves as one whenever the output register can take a result
    logic                 adv;
    logic                 busy;
    logic                 in_take;

    pix_ctrl_t            s2_ctrl;
    logic [ADDR_W-1:0]    s2_addr;
    logic [BIT_W-1:0]     s2_bit;

    // read-modify-write stage
    pix_ctrl_t            s3_ctrl_reg;
    logic [ADDR_W-1:0]    s3_addr_reg;
    logic [BIT_W-1:0]     s3_bit_reg;
    logic [WORD_BITS-1:0] rd_word;

    logic                 do_write;
    logic                 pix_hit;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    logic                 acc_reg;
    logic                 out_valid_reg;
    logic                 collided_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = busy || !adv;
    assign in_take  = in_valid && !in_stall;

    scb_locate #(
        .MAP_WIDTH   (MAP_WIDTH),
        .MAP_HEIGHT  (MAP_HEIGHT),
        .NUM_BITMAPS (NUM_BITMAPS)
    ) u_locate (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_take       (in_take),
        .req_type      (req_type),
        .bitmap_select (bitmap_select),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .col           (col),
        .row           (row),
        .pixel         (pixel),
        .last          (last),
        .s2_ctrl       (s2_ctrl),
        .s2_addr       (s2_addr),
        .s2_bit        (s2_bit)
    );

    // the read is issued as the pixel moves into the modify stage
    scb_store #(
        .MAP_WIDTH   (MAP_WIDTH),
        .MAP_HEIGHT  (MAP_HEIGHT),
        .NUM_BITMAPS (NUM_BITMAPS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (s2_addr),
        .rd_word (rd_word),
        .wr_en   (wr_en),
        .wr_addr (s3_addr_reg),
        .wr_data (wr_data),
        .busy    (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_ctrl_reg <= '0;
        else if (adv)
            s3_ctrl_reg <= s2_ctrl;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_addr_reg <= s2_addr;
            s3_bit_reg  <= s2_bit;
        end
    end

    // transparent pixels only matter to set and clear runs
    always_comb
    begin
        case (s3_ctrl_reg.req)
            REQ_TEST: do_write = 1'b0;
            REQ_MARK: do_write = s3_ctrl_reg.opaque;
            default:  do_write = 1'b1;
        endcase
    end

    always_comb
    begin
        wr_data             = rd_word;
        wr_data[s3_bit_reg] = s3_ctrl_reg.req != REQ_CLEAR;
    end

    assign pix_hit = s3_ctrl_reg.req == REQ_TEST && s3_ctrl_reg.in_map
                  && s3_ctrl_reg.opaque && rd_word[s3_bit_reg];

    // clipped pixels and out-of-range bitmaps never reach the store
    assign wr_en = adv && s3_ctrl_reg.valid && s3_ctrl_reg.in_map && do_write;

    // hit accumulator and output register; a write pixel closing a run reports no collision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            collided_reg  <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_ctrl_reg.valid && s3_ctrl_reg.last;
            if (s3_ctrl_reg.valid)
            begin
                if (s3_ctrl_reg.last)
                begin
                    collided_reg <= (s3_ctrl_reg.req == REQ_TEST) && (acc_reg || pix_hit);
                    acc_reg      <= 1'b0;
                end
                else if (pix_hit)
                begin
                    acc_reg <= 1'b1;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign collided  = collided_reg;

    // no pixel gets in while the bitmaps are still being cleared
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> in_stall)
        else $error("input accepted during clearing sweep");

    // test pixels never touch the store, and writes stay inside the map
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (s3_ctrl_reg.in_map && s3_ctrl_reg.req != REQ_TEST))
        else $error("store written by a test pixel or a clipped pixel");

    // a last pixel always gives a result and starts a fresh run
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s3_ctrl_reg.valid && s3_ctrl_reg.last) |=> (out_valid_reg && !acc_reg))
        else $error("last pixel did not close its run");

    // a frozen pipeline must not modify the store
    assert property (@(posedge clk) disable iff (!rst_n) !adv |-> !wr_en)
        else $error("store written while pipeline held");

endmodule

`default_nettype wire

// ===== test/sprite_collision_bitmap_test.sv =====
// self-checking testbench for the sprite collision bitmap block
// drives sprite pixel transactions, predicts every collided result and checks it
// depends on scb_pkg and sprite_collision_bitmap
`default_nettype none

module sprite_collision_bitmap_test;

    timeunit 1ns;
    timeprecision 1ps;

    import scb_pkg::*;

    localparam int MAP_W = MAP_WIDTH_DEF;
    localparam int MAP_H = MAP_HEIGHT_DEF;
    localparam int NUM_MAPS = NUM_BITMAPS_DEF;

    // result latency from the head of the block, plus a margin
    localparam int DRAIN_CYCLES = 3 + 8;

    // the limit stays above the reset sweep and the longest sender gaps and receiver stalls
    localparam int WATCHDOG_LIMIT = 40000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // input channel
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] req_type = REQ_TEST;
    logic [1:0] bitmap_select = 2'd0;
    logic signed [10:0] origin_x = '0;
    logic signed [10:0] origin_y = '0;
    logic [7:0] col = '0;
    logic [7:0] row = '0;
    logic [15:0] pixel = '0;
    logic last = 1'b0;

    // output channel
    logic out_valid;
    logic out_stall = 1'b0;
    logic collided;

    // predictor state: one bit per map pixel per bitmap, plus the running hit of a test run
    bit flag_map [NUM_MAPS][MAP_H][MAP_W];
    bit hit_pending = 1'b0;

    // collided values still owed by the block, oldest first
    bit collide_expected [$];

    int mismatches = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    // idling controls, changed by the test tasks
    bit idle_on = 1'b0;
    bit stall_on = 1'b0;
    int stall_hold = 0;
    int stall_roll;

    sprite_collision_bitmap u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .bitmap_select (bitmap_select),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .col           (col),
        .row           (row),
        .pixel         (pixel),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .collided      (collided)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // applies one pixel to the predicted bitmaps; returns 1 when the pixel closes a run
    function automatic bit predict_pixel(input req_t req, input logic [1:0] sel,
            input logic signed [10:0] ox, input logic signed [10:0] oy,
            input logic [7:0] c, input logic [7:0] r, input logic [15:0] pix,
            input logic lst, output bit collide);
        int px;
        int py;
        bit on_map;
        bit opaque;
        px = int'(ox) + int'(c);
        py = int'(oy) + int'(r);
        // clipping: off-map pixels and absent bitmaps touch nothing and read as clear
        on_map = (int'(sel) < NUM_MAPS) && (px >= 0) && (px < MAP_W)
                 && (py >= 0) && (py < MAP_H);
        opaque = (pix != 16'h0000);
        collide = 1'b0;
        case (req)
            REQ_TEST:
                if (on_map && opaque && flag_map[sel][py][px])
                    hit_pending = 1'b1;
            REQ_MARK:
                if (on_map && opaque)
                    flag_map[sel][py][px] = 1'b1;
            REQ_SET:
                if (on_map)
                    flag_map[sel][py][px] = 1'b1;
            default:
                if (on_map)
                    flag_map[sel][py][px] = 1'b0;
        endcase
        if (!lst)
            return 1'b0;
        // the closing item decides: a write closing a run reports no hit
        collide = (req == REQ_TEST) && hit_pending;
        hit_pending = 1'b0;
        return 1'b1;
    endfunction

    // sender gap length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sprite origin, weighted towards a small window so runs overlap and collide
    function automatic void pick_origin(output logic signed [10:0] ox,
                                        output logic signed [10:0] oy);
        int zone;
        zone = $urandom_range(0, 99);
        if (zone < 60)
        begin
            ox = 11'(int'($urandom_range(0, 40)) - 8);
            oy = 11'(int'($urandom_range(0, 40)) - 8);
        end
        else if (zone < 80)
        begin
            // straddling the right and bottom edges
            ox = 11'(int'($urandom_range(560, 615)));
            oy = 11'(int'($urandom_range(220, 250)));
        end
        else if (zone < 90)
        begin
            ox = 11'(int'($urandom_range(0, MAP_W - 1)));
            oy = 11'(int'($urandom_range(0, MAP_H - 1)));
        end
        else
        begin
            ox = 11'($urandom());
            oy = 11'($urandom());
        end
    endfunction

    function automatic int pick_size();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 6);
        return $urandom_range(7, 16);
    endfunction

    function automatic logic [15:0] pick_pixel(input int clear_pct);
        if (int'($urandom_range(0, 99)) < clear_pct)
            return 16'h0000;
        return 16'($urandom_range(1, 65535));
    endfunction

    // one input transaction: optional gap, then hold the payload until it is taken
    task automatic send_pixel(input req_t req, input logic [1:0] sel,
            input logic signed [10:0] ox, input logic signed [10:0] oy,
            input logic [7:0] c, input logic [7:0] r, input logic [15:0] pix,
            input logic lst);
        int gap;
        bit collide;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        bitmap_select <= sel;
        origin_x <= ox;
        origin_y <= oy;
        col <= c;
        row <= r;
        pixel <= pix;
        last <= lst;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_sent++;
        if (predict_pixel(req, sel, ox, oy, c, r, pix, lst, collide))
            collide_expected.push_back(collide);
    endtask

    // a rectangular sprite, row by row, last on its bottom-right pixel
    task automatic send_sprite(input req_t req, input logic [1:0] sel,
            input logic signed [10:0] ox, input logic signed [10:0] oy,
            input int col0, input int row0, input int w, input int h,
            input int clear_pct);
        for (int r = 0; r < h; r++)
        begin
            for (int c = 0; c < w; c++)
            begin
                send_pixel(req, sel, ox, oy, 8'(col0 + c), 8'(row0 + r),
                           pick_pixel(clear_pct), (r == h - 1) && (c == w - 1));
            end
        end
    endtask

    // hold the input off until every owed result has come out
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (collide_expected.size() != 0)
            @(posedge clk);
    endtask

    // corners, edges, clipping, transparency, absent bitmap and mixed runs
    task automatic test_directed_cases();
        idle_on = 1'b0;
        stall_on = 1'b0;
        // empty map reads clear
        send_pixel(REQ_TEST, 2'd0, 11'sd0, 11'sd0, 8'd0, 8'd0, 16'h0001, 1'b1);
        // mark top-left, then hit it, then a transparent test over it
        send_pixel(REQ_MARK, 2'd0, 11'sd0, 11'sd0, 8'd0, 8'd0, 16'hFFFF, 1'b1);
        send_pixel(REQ_TEST, 2'd0, 11'sd0, 11'sd0, 8'd0, 8'd0, 16'h8000, 1'b1);
        send_pixel(REQ_TEST, 2'd0, 11'sd0, 11'sd0, 8'd0, 8'd0, 16'h0000, 1'b1);
        // transparent mark at the bottom-right corner writes nothing
        send_pixel(REQ_MARK, 2'd0, 11'sd599, 11'sd239, 8'd0, 8'd0, 16'h0000, 1'b1);
        send_pixel(REQ_TEST, 2'd0, 11'sd599, 11'sd239, 8'd0, 8'd0, 16'h0001, 1'b1);
        // set with a transparent pixel still writes, reached through the maximum column offset
        send_pixel(REQ_SET, 2'd0, 11'sd344, 11'sd0, 8'd255, 8'd239, 16'h0000, 1'b1);
        send_pixel(REQ_TEST, 2'd0, 11'sd599, 11'sd239, 8'd0, 8'd0, 16'h0001, 1'b1);
        send_pixel(REQ_CLEAR, 2'd0, 11'sd599, 11'sd239, 8'd0, 8'd0, 16'h0000, 1'b1);
        send_pixel(REQ_TEST, 2'd0, 11'sd599, 11'sd239, 8'd0, 8'd0, 16'h7FFF, 1'b1);
        // off-map writes at the origin extremes and just past the left edge, tests past right and bottom
        send_pixel(REQ_MARK, 2'd0, -11'sd1024, -11'sd1024, 8'd255, 8'd255, 16'h0001, 1'b1);
        send_pixel(REQ_SET, 2'd0, 11'sd1023, 11'sd1023, 8'd255, 8'd255, 16'hFFFF, 1'b1);
        send_pixel(REQ_SET, 2'd0, -11'sd1, 11'sd0, 8'd0, 8'd0, 16'h0001, 1'b1);
        send_pixel(REQ_TEST, 2'd0, 11'sd600, 11'sd0, 8'd0, 8'd0, 16'h0001, 1'b1);
        send_pixel(REQ_TEST, 2'd0, 11'sd0, 11'sd240, 8'd0, 8'd0, 16'h0001, 1'b1);
        // negative origin pulled back onto the map by the offsets, separate bitmaps
        send_pixel(REQ_SET, 2'd1, -11'sd200, -11'sd100, 8'd250, 8'd150, 16'h0000, 1'b1);
        send_pixel(REQ_TEST, 2'd0, 11'sd50, 11'sd50, 8'd0, 8'd0, 16'h0001, 1'b1);
        send_pixel(REQ_TEST, 2'd1, 11'sd50, 11'sd50, 8'd0, 8'd0, 16'h0001, 1'b1);
        // bitmap that does not exist: writes vanish, tests read clear
        send_pixel(REQ_SET, 2'd3, 11'sd10, 11'sd10, 8'd0, 8'd0, 16'h0001, 1'b1);
        send_pixel(REQ_TEST, 2'd3, 11'sd10, 11'sd10, 8'd0, 8'd0, 16'h0001, 1'b1);
        send_pixel(REQ_TEST, 2'd0, 11'sd10, 11'sd10, 8'd0, 8'd0, 16'h0001, 1'b1);
        // mixed runs: a hit followed by a closing mark reports nothing
        send_pixel(REQ_MARK, 2'd2, 11'sd5, 11'sd5, 8'd0, 8'd0, 16'h7FFF, 1'b1);
        send_pixel(REQ_TEST, 2'd2, 11'sd5, 11'sd5, 8'd0, 8'd0, 16'h0001, 1'b0);
        send_pixel(REQ_MARK, 2'd2, 11'sd5, 11'sd5, 8'd1, 8'd0, 16'h0001, 1'b1);
        // an early hit survives a later miss in the same test run
        send_pixel(REQ_TEST, 2'd2, 11'sd5, 11'sd5, 8'd0, 8'd0, 16'h0001, 1'b0);
        send_pixel(REQ_TEST, 2'd2, 11'sd100, 11'sd100, 8'd0, 8'd0, 16'h0001, 1'b1);
    endtask

    // the sender stops until the block has caught up, then probes what was just drawn
    task automatic test_drain_then_probe();
        idle_on = 1'b1;
        stall_on = 1'b1;
        send_sprite(REQ_MARK, 2'd0, 11'sd12, 11'sd12, 0, 0, 4, 4, 0);
        wait_for_results();
        send_sprite(REQ_TEST, 2'd0, 11'sd14, 11'sd14, 0, 0, 4, 4, 20);
        send_sprite(REQ_CLEAR, 2'd0, 11'sd12, 11'sd12, 0, 0, 3, 3, 50);
        send_sprite(REQ_TEST, 2'd0, 11'sd12, 11'sd12, 0, 0, 4, 4, 0);
    endtask

    // well-formed sprite runs with random content, often drawn then tested in place
    task automatic test_sprite_runs();
        int stop_at;
        int roll;
        int w;
        int h;
        int col0;
        int row0;
        logic [1:0] sel;
        logic signed [10:0] ox;
        logic signed [10:0] oy;
        req_t req;
        bit paused;
        stop_at = items_sent + 560;
        paused = 1'b0;
        while (items_sent < stop_at)
        begin
            // stretches with no idling on one or both sides
            idle_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            pick_origin(ox, oy);
            w = pick_size();
            h = pick_size();
            col0 = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : 0;
            row0 = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : 0;
            sel = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            roll = $urandom_range(0, 99);
            if (roll < 40)
                req = REQ_TEST;
            else if (roll < 75)
                req = REQ_MARK;
            else if (roll < 85)
                req = REQ_SET;
            else
                req = REQ_CLEAR;
            send_sprite(req, sel, ox, oy, col0, row0, w, h, $urandom_range(0, 60));
            // draw then test close by, so the test has something to hit
            if ($urandom_range(0, 9) < 3)
                send_sprite(REQ_TEST, sel, 11'(ox + $urandom_range(0, 4) - 2),
                            11'(oy + $urandom_range(0, 4) - 2), col0, row0,
                            pick_size(), pick_size(), $urandom_range(0, 40));
            if (!paused && items_sent > stop_at - 280)
            begin
                wait_for_results();
                paused = 1'b1;
            end
        end
    endtask

    // unstructured transactions: runs broken off, mixed operations, any field value
    task automatic test_stream_noise();
        logic signed [10:0] ox;
        logic signed [10:0] oy;
        idle_on = 1'b1;
        stall_on = 1'b1;
        for (int n = 0; n < 150; n++)
        begin
            if ($urandom_range(0, 1) == 0)
                pick_origin(ox, oy);
            else
            begin
                ox = 11'($urandom());
                oy = 11'($urandom());
            end
            send_pixel(req_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), ox, oy,
                       8'($urandom()), 8'($urandom()), pick_pixel(30),
                       (n == 149) || ($urandom_range(0, 3) == 0));
        end
    endtask

    // drain, let the pipeline settle, then give the verdict
    task automatic finish_run();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (collide_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", collide_expected.size()));
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    endtask

    initial
    begin
        // reset once; the block then sweeps its store with in_stall high
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_drain_then_probe();
        test_sprite_runs();
        test_stream_noise();
        finish_run();
    end

    // receiver: random stall lengths, mostly short with the odd long one
    always @(posedge clk)
    begin
        if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else if (!stall_on)
            out_stall <= 1'b0;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70)
                out_stall <= 1'b0;
            else if (stall_roll < 95)
            begin
                out_stall <= 1'b1;
                stall_hold <= $urandom_range(0, 3);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_hold <= $urandom_range(10, 40);
            end
        end
    end

    // every output transaction is matched against the oldest owed result
    always @(posedge clk)
    begin : check_result
        bit want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (collide_expected.size() == 0)
                report_mismatch($sformatf("collided=%b with no result owed", collided));
            else
            begin
                want = collide_expected.pop_front();
                if (collided !== want)
                    report_mismatch($sformatf("collided=%b, wanted %b", collided, want));
            end
        end
    end

    // ends a hung run: too long with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

endmodule

`default_nettype wire
